// ===== src/clmd_pkg.sv =====
// Shared types and constants for the content-length message deframer.
`default_nettype none
package clmd_pkg;

  // Width of the length value and of the body counters.
  localparam int LEN_BITS = 32;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_BYTE    = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_INVALID = 2'd2,
    ST_EOF     = 2'd3
  } status_t;

  // One input transaction.
  typedef struct packed {
    logic       req_type;
    logic [7:0] in_byte;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    status_t    status;
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // Result of one parse step: whether a result is produced, and its value.
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } step_result_t;

endpackage
`default_nettype wire

// ===== src/clmd_parser.sv =====
// Header parser and body counter: the frame state and the per-byte update.
`default_nettype none
module clmd_parser (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  fire,
  input  wire clmd_pkg::in_item_t    item,
  output clmd_pkg::step_result_t     result
);
  import clmd_pkg::*;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;

  localparam logic [3:0] POS_FULL = 4'd14;
  localparam logic [3:0] POS_MISS = 4'd15;

  typedef enum logic [2:0] {
    PH_SKIP_SPTAB = 3'd0,
    PH_SKIP_WS    = 3'd1,
    PH_SIGN       = 3'd2,
    PH_DIGITS     = 3'd3,
    PH_DONE       = 3'd4
  } phase_t;

  // Per-line parse state.
  typedef struct packed {
    logic                cr_held;
    logic                line_nonempty;
    logic                colon_seen;
    logic [3:0]          match_pos;
    phase_t              phase;
    logic [LEN_BITS-1:0] accum;
    logic                bad;
  } line_t;

  localparam line_t LINE_CLEAR = '{
    cr_held: 1'b0, line_nonempty: 1'b0, colon_seen: 1'b0, match_pos: 4'd0,
    phase: PH_SKIP_SPTAB, accum: '0, bad: 1'b0};

  // Lowercase header name, one character per match position.
  function automatic logic [7:0] hdr_char(input logic [3:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = "c";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "l";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // One character of a header line, including the value parse after the colon.
  function automatic line_t line_char(input line_t l, input logic [7:0] c);
    line_t               r;
    logic [7:0]          lc;
    logic                go;
    logic [LEN_BITS+3:0] wide;
    logic [LEN_BITS+3:0] sum;
    r = l;
    r.line_nonempty = 1'b1;
    go = 1'b1;
    lc = c;
    wide = {4'd0, l.accum};
    sum = (wide << 3) + (wide << 1) + {{(LEN_BITS){1'b0}}, c[3:0]};
    if (!l.colon_seen) begin
      if (c == CH_COLON) begin
        r.colon_seen = 1'b1;
      end else begin
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
          lc = c + 8'd32;
        end
        if (l.match_pos < POS_FULL && lc == hdr_char(l.match_pos)) begin
          r.match_pos = l.match_pos + 4'd1;
        end else begin
          r.match_pos = POS_MISS;
        end
      end
    end else if (l.match_pos == POS_FULL) begin
      // Leading spaces and tabs.
      if (r.phase == PH_SKIP_SPTAB) begin
        if (c == CH_SPACE || c == CH_TAB) begin
          go = 1'b0;
        end else begin
          r.phase = PH_SKIP_WS;
        end
      end
      // Further whitespace, then an optional plus sign.
      if (go && r.phase == PH_SKIP_WS) begin
        if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR) begin
          go = 1'b0;
        end else if (c == CH_PLUS) begin
          r.phase = PH_SIGN;
          go = 1'b0;
        end else if (is_digit(c)) begin
          r.phase = PH_SIGN;
        end else begin
          r.bad = 1'b1;
          r.phase = PH_DONE;
          go = 1'b0;
        end
      end
      // Decimal digits with an overflow check on the widened product.
      if (go && (r.phase == PH_SIGN || r.phase == PH_DIGITS)) begin
        if (is_digit(c)) begin
          if (sum[LEN_BITS+3:LEN_BITS] != 4'd0) begin
            r.bad = 1'b1;
            r.phase = PH_DONE;
          end else begin
            r.accum = sum[LEN_BITS-1:0];
            r.phase = PH_DIGITS;
          end
        end else begin
          if (r.phase == PH_SIGN) begin
            r.bad = 1'b1;
          end
          r.phase = PH_DONE;
        end
      end
    end
    return r;
  endfunction

  // Frame state.
  logic                in_body;
  logic                length_seen;
  logic                frame_invalid;
  logic [LEN_BITS-1:0] body_length;
  logic [LEN_BITS-1:0] body_left;
  line_t               line;

  logic                in_body_next;
  logic                length_seen_next;
  logic                frame_invalid_next;
  logic [LEN_BITS-1:0] body_length_next;
  logic [LEN_BITS-1:0] body_left_next;
  line_t               line_next;

  // Next-state and result logic for one transaction.
  always_comb begin
    logic [7:0] c;
    logic       do_end;
    logic       at_eof;
    logic       clear_all;
    status_t    st;
    c = item.in_byte;
    do_end = 1'b0;
    at_eof = 1'b0;
    clear_all = 1'b0;
    st = ST_EOF;
    in_body_next = in_body;
    length_seen_next = length_seen;
    frame_invalid_next = frame_invalid;
    body_length_next = body_length;
    body_left_next = body_left;
    line_next = line;
    result = '0;

    if (item.req_type) begin
      // End of input; a lone held CR still counts as a blank line.
      if (!in_body && line.cr_held && !line.line_nonempty) begin
        do_end = 1'b1;
        at_eof = 1'b1;
      end else begin
        clear_all = 1'b1;
        result.valid = 1'b1;
        result.item.status = ST_EOF;
        result.item.last = 1'b1;
      end
    end else if (in_body) begin
      // Body byte passthrough.
      result.valid = 1'b1;
      result.item.status = ST_BYTE;
      result.item.out_byte = c;
      result.item.last = (body_left <= LEN_BITS'(1));
      if (body_left <= LEN_BITS'(1)) begin
        clear_all = 1'b1;
      end else begin
        body_left_next = body_left - LEN_BITS'(1);
      end
    end else if (c == CH_LF) begin
      if (!line.line_nonempty) begin
        line_next = LINE_CLEAR;
        do_end = 1'b1;
      end else begin
        // Close a header line and commit its value.
        if (line.colon_seen && line.match_pos == POS_FULL &&
            line.phase != PH_SKIP_SPTAB) begin
          if (line.phase == PH_SKIP_WS || line.phase == PH_SIGN || line.bad) begin
            frame_invalid_next = 1'b1;
          end else begin
            body_length_next = line.accum;
            length_seen_next = 1'b1;
          end
        end
        line_next = LINE_CLEAR;
      end
    end else begin
      // Ordinary header byte; a held CR is replayed as a line character first.
      if (line.cr_held) begin
        line_next = line_char(line_next, CH_CR);
      end
      line_next.cr_held = 1'b0;
      if (c == CH_CR) begin
        line_next.cr_held = 1'b1;
      end else begin
        line_next = line_char(line_next, c);
      end
    end

    // End of the header block.
    if (do_end) begin
      if (frame_invalid || !length_seen) begin
        st = ST_INVALID;
      end else if (body_length == '0) begin
        st = ST_EMPTY;
      end else begin
        st = ST_EOF;
      end
      if (!frame_invalid && length_seen && body_length != '0 && !at_eof) begin
        line_next = LINE_CLEAR;
        in_body_next = 1'b1;
        body_left_next = body_length;
      end else begin
        clear_all = 1'b1;
        result.valid = 1'b1;
        result.item.status = st;
        result.item.last = 1'b1;
      end
    end

    if (clear_all) begin
      line_next = LINE_CLEAR;
      in_body_next = 1'b0;
      length_seen_next = 1'b0;
      frame_invalid_next = 1'b0;
      body_length_next = '0;
      body_left_next = '0;
    end
  end

  // State registers, updated once per processed transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_body <= 1'b0;
      length_seen <= 1'b0;
      frame_invalid <= 1'b0;
      body_length <= '0;
      body_left <= '0;
      line <= LINE_CLEAR;
    end else if (fire) begin
      in_body <= in_body_next;
      length_seen <= length_seen_next;
      frame_invalid <= frame_invalid_next;
      body_length <= body_length_next;
      body_left <= body_left_next;
      line <= line_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/content_length_message_deframer.sv =====
// Top level of the content-length message deframer: input and result registers.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  clmd_pkg::in_item_t
//   rsp      out        rsp_valid / rsp_stall  clmd_pkg::out_item_t
//
// One transaction per cycle is sustained while rsp is not stalled; each item
// is held in the input register and its result (if any) is then registered
// in the result register. Reset is synchronous and clears the frame state
// and both valid flags. A stall on rsp holds the result register and reaches
// req_stall only while the input register is full.
`default_nettype none
module content_length_message_deframer (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire clmd_pkg::in_item_t   req,
  output logic                      rsp_valid,
  input  wire logic                 rsp_stall,
  output clmd_pkg::out_item_t       rsp
);
  import clmd_pkg::*;

  logic         s1_valid;
  in_item_t     s1_item;
  logic         advance;
  logic         req_take;
  step_result_t step;

  // The held item moves on when the result register is free or draining.
  assign advance   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !advance;
  assign req_take  = req_valid && !req_stall;

  clmd_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (s1_item),
    .result (step)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_item <= req;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= step.valid;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.valid) begin
      rsp <= step.item;
    end
  end

endmodule
`default_nettype wire
